// File: rtl/unique_name_table_core_assert.svh
// assertion macros shared by the name table checker
// expects clk and arst_n to be visible where a macro is used
`ifndef UNIQUE_NAME_TABLE_CORE_ASSERT_SVH
`define UNIQUE_NAME_TABLE_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UNT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("name table assertion failed");

// next-cycle implication, disabled while in reset
`define UNT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("name table assertion failed");

`endif

// File: rtl/unt_pkg.sv
// shared types, codes and helpers of the unique name table
// no dependencies
package unt_pkg;

	localparam int unsigned TableDepthDef = 16;
	localparam int unsigned NAME_W        = 72;
	localparam int unsigned CNT_OUT_W     = 5;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_LIST   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_EXISTS    = 3'd1,
		ST_DELETED   = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_LISTED    = 3'd4,
		ST_FULL      = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	// a name ends at its first zero byte, later bytes are cleared
	function automatic logic [NAME_W-1:0] canon_name(logic [63:0] lo, logic [7:0] ninth);
		logic [NAME_W-1:0] n;
		logic              ended;
		int                i;
		ended = 1'b0;
		n     = '0;
		for (i = 0; i < 8; i++) begin
			if (lo[8*i +: 8] == 8'd0) begin
				ended = 1'b1;
			end
			n[8*i +: 8] = ended ? 8'd0 : lo[8*i +: 8];
		end
		n[71:64] = ended ? 8'd0 : ninth;
		return n;
	endfunction

endpackage

// File: rtl/unt_if.sv
// request and response channel interfaces of the unique name table
// no dependencies
interface unt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] name_low;
	logic [7:0]  name_ninth;

	modport source (output valid, output op, output name_low, output name_ninth, input ready);
	modport sink (input valid, input op, input name_low, input name_ninth, output ready);
endinterface

interface unt_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] entry_low;
	logic [7:0]  entry_ninth;
	logic [4:0]  entry_count;
	logic        last;

	modport source (output valid, output status, output entry_low, output entry_ninth,
		output entry_count, output last, input ready);
	modport sink (input valid, input status, input entry_low, input entry_ninth,
		input entry_count, input last, output ready);
endinterface

// File: rtl/unique_name_table_core.sv
// unique name table: create, delete and list over a table held in one ram
// a search reads one entry per cycle and stops at a match, a delete then moves
// each later entry down one per cycle; a list reads its first entry at accept
// and loads one item per cycle while the response slot is free, else it waits
// reset clears the entry count and control state; the ram is not cleared, no sweep
// depends on unt_pkg, unt_if, unt_ram
module unique_name_table_core import unt_pkg::*; #(
	parameter int unsigned TABLE_DEPTH = TableDepthDef
) (
	input  logic      clk,
	input  logic      arst_n,
	unt_req_if.sink   req,
	unt_rsp_if.source rsp
);

	localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SRCH  = 5'b00010,
		S_SHIFT = 5'b00100,
		S_LIST  = 5'b01000,
		S_RESP  = 5'b10000
	} state_t;

	state_t            state_q, state_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CNT_W-1:0]  idx_q, idx_d;
	status_t           status_q, status_d;
	op_t               op_q;
	logic [NAME_W-1:0] name_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	logic [63:0]          out_low_q;
	logic [7:0]           out_ninth_q;
	logic [CNT_OUT_W-1:0] out_count_q;
	logic                 out_last_q;

	logic              load_out;
	status_t           out_status_d;
	logic [NAME_W-1:0] out_entry_d;
	logic              out_last_d;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [NAME_W-1:0] ram_wdata, ram_rdata;

	logic [NAME_W-1:0] in_name;
	op_t               in_op;
	logic              accept, slot_free, hit, at_end, full;
	logic [CNT_W-1:0]  idx_nxt, idx_nxt2;

	unt_ram #(
		.WIDTH (NAME_W),
		.DEPTH (TABLE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_name   = canon_name(req.name_low, req.name_ninth);
	assign in_op     = op_t'(req.op);
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid & req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign idx_nxt   = idx_q + CNT_W'(1);
	assign idx_nxt2  = idx_q + CNT_W'(2);
	assign hit       = (ram_rdata == name_q);
	assign at_end    = (idx_nxt == count_q);
	assign full      = (count_q == CNT_W'(TABLE_DEPTH));

	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		idx_d        = idx_q;
		status_d     = status_q;
		ram_we       = 1'b0;
		ram_waddr    = '0;
		ram_wdata    = name_q;
		ram_re       = 1'b0;
		ram_raddr    = '0;
		load_out     = 1'b0;
		out_status_d = status_q;
		out_entry_d  = '0;
		out_last_d   = 1'b1;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					idx_d  = '0;
					ram_re = 1'b1;
					case (in_op)
						OP_CREATE: begin
							if (count_q == '0) begin
								ram_we    = 1'b1;
								ram_wdata = in_name;
								count_d   = CNT_W'(1);
								status_d  = ST_ADDED;
								state_d   = S_RESP;
							end else begin
								state_d = S_SRCH;
							end
						end
						OP_DELETE: begin
							if (count_q == '0) begin
								status_d = ST_NOT_FOUND;
								state_d  = S_RESP;
							end else begin
								state_d = S_SRCH;
							end
						end
						OP_LIST: begin
							if (count_q == '0) begin
								status_d = ST_EMPTY;
								state_d  = S_RESP;
							end else begin
								state_d = S_LIST;
							end
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_SRCH: begin
				// compare entry idx while fetching the next one
				ram_re    = 1'b1;
				ram_raddr = idx_nxt[AW-1:0];
				if (hit) begin
					if (op_q == OP_CREATE) begin
						status_d = ST_EXISTS;
						state_d  = S_RESP;
					end else begin
						state_d = S_SHIFT;
					end
				end else if (at_end) begin
					state_d = S_RESP;
					if (op_q == OP_CREATE) begin
						if (full) begin
							status_d = ST_FULL;
						end else begin
							ram_we    = 1'b1;
							ram_waddr = count_q[AW-1:0];
							count_d   = count_q + CNT_W'(1);
							status_d  = ST_ADDED;
						end
					end else begin
						status_d = ST_NOT_FOUND;
					end
				end else begin
					idx_d = idx_nxt;
				end
			end
			S_SHIFT: begin
				// read data holds entry idx+1, it moves down to idx
				if (at_end) begin
					count_d  = count_q - CNT_W'(1);
					status_d = ST_DELETED;
					state_d  = S_RESP;
				end else begin
					ram_we    = 1'b1;
					ram_waddr = idx_q[AW-1:0];
					ram_wdata = ram_rdata;
					ram_re    = 1'b1;
					ram_raddr = idx_nxt2[AW-1:0];
					idx_d     = idx_nxt;
				end
			end
			S_LIST: begin
				if (slot_free) begin
					load_out     = 1'b1;
					out_status_d = ST_LISTED;
					out_entry_d  = ram_rdata;
					out_last_d   = at_end;
					if (at_end) begin
						state_d = S_IDLE;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = idx_nxt[AW-1:0];
						idx_d     = idx_nxt;
					end
				end
			end
			S_RESP: begin
				if (slot_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (accept) begin
			op_q   <= in_op;
			name_q <= in_name;
		end
		if (load_out) begin
			out_status_q <= out_status_d;
			out_low_q    <= out_entry_d[63:0];
			out_ninth_q  <= out_entry_d[71:64];
			out_count_q  <= CNT_OUT_W'(count_q);
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.status      = out_status_q;
	assign rsp.entry_low   = out_low_q;
	assign rsp.entry_ninth = out_ninth_q;
	assign rsp.entry_count = out_count_q;
	assign rsp.last        = out_last_q;

endmodule

// File: rtl/unt_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module unt_ram #(
	parameter int unsigned WIDTH = 72,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/unt_checker.sv
// port-level checks of the unique name table, bound to the top level
// depends on unt_pkg and unique_name_table_core_assert.svh
`include "unique_name_table_core_assert.svh"

module unt_checker import unt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  out_status,
	input logic [63:0] out_low,
	input logic [7:0]  out_ninth,
	input logic [4:0]  out_count,
	input logic        out_last
);

	// only listed entries carry name bytes
	`UNT_ASSERT_NOW(a_zero_payload, out_valid && out_status != ST_LISTED, out_low == 64'd0 && out_ninth == 8'd0)

	// every non-list result closes its command
	`UNT_ASSERT_NOW(a_single_last, out_valid && out_status != ST_LISTED, out_last)

	// an empty report only comes from an empty table
	`UNT_ASSERT_NOW(a_empty_count, out_valid && out_status == ST_EMPTY, out_count == 5'd0)

	// a stalled item holds
	`UNT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_last))

endmodule

bind unique_name_table_core unt_checker u_unt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_status (rsp.status),
	.out_low    (rsp.entry_low),
	.out_ninth  (rsp.entry_ninth),
	.out_count  (rsp.entry_count),
	.out_last   (rsp.last)
);
